// File: rtl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared constants and types for the stuffed packet framer.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int          PACKET_BYTES_DEF = 64;
    localparam int          QUEUE_DEPTH_DEF  = 4;
    localparam logic [7:0]  START_BYTE       = 8'hEE;

    // one transaction yields at most start + 2 code + 2 data bytes
    localparam int          MAX_RESULTS      = 5;
    localparam int          POS_W            = 3;

    // framing plan for one input transaction, built by the front end
    typedef struct packed {
        logic       open;       // emit a start byte first
        logic [7:0] code;
        logic [1:0] code_cnt;   // 0, 1, or 2 (stuffed)
        logic [7:0] data;
        logic [1:0] data_cnt;   // 0, 1, or 2 (stuffed)
        logic       last_cmd;
    } plan_t;

endpackage

// File: rtl/stuffed_packet_framer.sv
// ----------------------------------------------------------------------------
// stuffed_packet_framer
// Frames commands into byte-stuffed packets, one output byte per transaction.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    s_action, s_data_byte, s_last_of_command
// m_       out  m_valid/m_ready    m_tx_byte, m_packet_start, m_command_done,
//                                  m_last_of_run
// cfg_     in   cfg_valid/cfg_ready cfg_data (continuation code)
//
// An input transaction is classified in its accept cycle; the back end sends
// its 1 to 5 bytes at one per cycle unless m_ready stalls, so sustained
// rate is one byte per cycle. Each plan is queued, then its bytes registered.
// The plan queue (QUEUE_DEPTH entries) lets s_ accept while m_ is stalled.
// aresetn is synchronous; it clears packet fill, queue, and code to zero.
// ----------------------------------------------------------------------------
module stuffed_packet_framer #(
    parameter int PACKET_BYTES = spf_pkg::PACKET_BYTES_DEF,
    parameter int QUEUE_DEPTH  = spf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_of_command,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_packet_start,
    output logic       m_command_done,
    output logic       m_last_of_run,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    spf_pkg::plan_t push_plan, head_plan;
    logic           q_push, q_pop, q_full, q_empty;

    spf_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_data_byte       (s_data_byte),
        .s_last_of_command (s_last_of_command),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_plan            (push_plan)
    );

    spf_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_plan (push_plan),
        .pop     (q_pop),
        .rd_plan (head_plan),
        .full    (q_full),
        .empty   (q_empty)
    );

    spf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_plan         (head_plan),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tx_byte      (m_tx_byte),
        .m_packet_start (m_packet_start),
        .m_command_done (m_command_done),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

// File: rtl/spf_front.sv
// ----------------------------------------------------------------------------
// spf_front
// Accepts input transactions, tracks packet fill and builds a framing plan.
// ----------------------------------------------------------------------------
module spf_front #(
    parameter int PACKET_BYTES = spf_pkg::PACKET_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_action,
    input  logic [7:0]     s_data_byte,
    input  logic           s_last_of_command,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_data,
    input  logic           q_full,
    output logic           q_push,
    output spf_pkg::plan_t q_plan
);

    localparam int FILL_W = $clog2(PACKET_BYTES + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam logic [SUM_W-1:0] LIMIT = SUM_W'(PACKET_BYTES);

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        cont_code_reg;

    logic              accept;
    logic [1:0]        need;
    logic [1:0]        cont_cnt;
    logic [SUM_W-1:0]  fill_ext;
    logic [SUM_W-1:0]  add_sum;
    logic [SUM_W-1:0]  base;
    logic [SUM_W-1:0]  base_sum;
    logic [SUM_W-1:0]  new_fill;
    logic              fits_open;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign q_push    = accept;

    assign need      = (s_data_byte == spf_pkg::START_BYTE) ? 2'd2 : 2'd1;
    assign cont_cnt  = (cont_code_reg == spf_pkg::START_BYTE) ? 2'd2 : 2'd1;
    assign fill_ext  = {1'b0, fill_reg};
    assign add_sum   = fill_ext + SUM_W'(need);
    assign fits_open = (fill_reg != '0) && (add_sum <= LIMIT);
    // fresh follow-on packet: start byte plus continuation code
    assign base      = SUM_W'(1) + SUM_W'(cont_cnt);
    assign base_sum  = base + SUM_W'(need);

    always_comb begin
        q_plan          = '0;
        q_plan.last_cmd = s_last_of_command;
        new_fill        = '0;
        if (!s_action) begin
            q_plan.open     = 1'b1;
            q_plan.code     = s_data_byte;
            q_plan.code_cnt = need;
            new_fill        = SUM_W'(1) + SUM_W'(need);
        end else if (fits_open) begin
            q_plan.data     = s_data_byte;
            q_plan.data_cnt = need;
            new_fill        = add_sum;
        end else begin
            q_plan.open     = 1'b1;
            q_plan.code     = cont_code_reg;
            q_plan.code_cnt = cont_cnt;
            q_plan.data     = s_data_byte;
            if (base_sum <= LIMIT) begin
                q_plan.data_cnt = need;
                new_fill        = base_sum;
            end else begin
                // byte fits no fresh packet (tiny packet size): dropped
                q_plan.data_cnt = 2'd0;
                new_fill        = base;
            end
        end
        fill_next = s_last_of_command ? '0 : new_fill[FILL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            cont_code_reg <= '0;
        end else begin
            if (accept) begin
                fill_reg <= fill_next;
            end
            if (cfg_valid && cfg_ready) begin
                cont_code_reg <= cfg_data;
            end
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, fill_reg} <= LIMIT)
        else $error("packet fill above packet size");

endmodule

// File: rtl/spf_fifo.sv
// ----------------------------------------------------------------------------
// spf_fifo
// Small plan queue between front and back end.
// ----------------------------------------------------------------------------
module spf_fifo #(
    parameter int QUEUE_DEPTH = spf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  spf_pkg::plan_t wr_plan,
    input  logic           pop,
    output spf_pkg::plan_t rd_plan,
    output logic           full,
    output logic           empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    spf_pkg::plan_t    mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_plan = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_plan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("plan queue count above depth");

    a_push_only: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("plan queue count lost a push");

endmodule

// File: rtl/spf_back.sv
// ----------------------------------------------------------------------------
// spf_back
// Walks the plan at the queue head and sends one byte per transaction.
// ----------------------------------------------------------------------------
module spf_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  spf_pkg::plan_t        q_plan,
    input  logic                  q_empty,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_tx_byte,
    output logic                  m_packet_start,
    output logic                  m_command_done,
    output logic                  m_last_of_run
);

    localparam int PW = spf_pkg::POS_W;

    logic [PW-1:0] pos_reg, pos_next;
    logic          m_valid_reg;
    logic [7:0]    tx_byte_reg;
    logic          start_reg, done_reg, run_reg;

    logic [PW-1:0] n_open, n_head, n_total;
    logic          emit, is_last;
    logic [7:0]    sel_byte;
    logic          sel_start;

    assign n_open  = PW'(q_plan.open);
    assign n_head  = n_open + PW'(q_plan.code_cnt);
    assign n_total = n_head + PW'(q_plan.data_cnt);
    assign is_last = (pos_reg == n_total - PW'(1));
    assign emit    = !q_empty && (!m_valid_reg || m_ready);
    assign q_pop   = emit && is_last;

    always_comb begin
        sel_start = 1'b0;
        if (pos_reg < n_open) begin
            sel_byte  = spf_pkg::START_BYTE;
            sel_start = 1'b1;
        end else if (pos_reg < n_head) begin
            sel_byte = q_plan.code;
        end else begin
            sel_byte = q_plan.data;
        end
        pos_next = is_last ? '0 : pos_reg + PW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                pos_reg     <= pos_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            tx_byte_reg <= sel_byte;
            start_reg   <= sel_start;
            run_reg     <= is_last;
            done_reg    <= is_last && q_plan.last_cmd;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_tx_byte      = tx_byte_reg;
    assign m_packet_start = start_reg;
    assign m_command_done = done_reg;
    assign m_last_of_run  = run_reg;

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= PW'(spf_pkg::MAX_RESULTS - 1))
        else $error("byte position past largest plan");

    a_pop_marks_run: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid && m_last_of_run)
        else $error("plan retired without end-of-run byte");

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// stuffed_packet_framer testbench
// Drives header and payload transactions with random gaps and receiver
// stalls. It predicts every framed byte (start delimiter, stuffed 0xEE,
// packet split at PACKET_BYTES, continuation code) and checks each output
// transaction against the oldest predicted byte.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          FRAME_BYTES  = spf_pkg::PACKET_BYTES_DEF;
    localparam bit          ACT_HEADER   = 1'b0;
    localparam bit          ACT_PAYLOAD  = 1'b1;
    localparam int          RANDOM_ITEMS = 40;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          DRAIN_CYCLES = 8;
    localparam int unsigned LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       packet_start;
        logic       command_done;
        logic       last_of_run;
    } tx_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid;
    logic       s_ready;
    logic       s_action;
    logic [7:0] s_data_byte;
    logic       s_last_of_command;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_tx_byte;
    logic       m_packet_start;
    logic       m_command_done;
    logic       m_last_of_run;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    // framer state as predicted
    logic [6:0]  pkt_fill  = '0;
    logic [7:0]  cont_code = '0;
    tx_byte_t    pending_tx[$];

    int          errors = 0;
    int unsigned cycle_count = 0;
    int          random_sent = 0;
    bit          idle_on = 1'b1;
    bit          rx_hold_req = 1'b0;
    int          rx_gap = 0;

    stuffed_packet_framer #(
        .PACKET_BYTES (FRAME_BYTES)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_data_byte       (s_data_byte),
        .s_last_of_command (s_last_of_command),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_tx_byte         (m_tx_byte),
        .m_packet_start    (m_packet_start),
        .m_command_done    (m_command_done),
        .m_last_of_run     (m_last_of_run),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic void emit_byte(logic [7:0] b, logic start);
        tx_byte_t r;
        r.tx_byte      = b;
        r.packet_start = start;
        r.command_done = 1'b0;
        r.last_of_run  = 1'b0;
        pending_tx.push_back(r);
    endfunction

    // append with 0xEE doubling; returns 0 when the byte does not fit
    function automatic bit stuff_byte(logic [7:0] b);
        int need;
        need = (b == spf_pkg::START_BYTE) ? 2 : 1;
        if (int'(pkt_fill) + need > FRAME_BYTES)
            return 1'b0;
        repeat (need) emit_byte(b, 1'b0);
        pkt_fill = 7'(int'(pkt_fill) + need);
        return 1'b1;
    endfunction

    function automatic void open_packet(logic [7:0] code);
        emit_byte(spf_pkg::START_BYTE, 1'b1);
        pkt_fill = 7'd1;
        void'(stuff_byte(code));
    endfunction

    function automatic void frame_item(logic act, logic [7:0] b, logic last);
        tx_byte_t tail;
        if (act == ACT_HEADER) begin
            open_packet(b);
        end else if (pkt_fill == 0 || !stuff_byte(b)) begin
            open_packet(cont_code);
            void'(stuff_byte(b));
        end
        tail = pending_tx.pop_back();
        tail.last_of_run = 1'b1;
        if (last) begin
            tail.command_done = 1'b1;
            pkt_fill = '0;
        end
        pending_tx.push_back(tail);
    endfunction

    // ---------------- monitor and checker ----------------

    always @(posedge aclk) begin : tx_check
        tx_byte_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                cont_code = cfg_data;
            if (s_valid && s_ready)
                frame_item(s_action, s_data_byte, s_last_of_command);
            if (m_valid && m_ready) begin
                if (pending_tx.size() == 0) begin
                    $error("unexpected byte %02h with nothing pending", m_tx_byte);
                    errors++;
                end else begin
                    want = pending_tx.pop_front();
                    if (m_tx_byte !== want.tx_byte) begin
                        $error("tx_byte: expected %02h, actual %02h",
                               want.tx_byte, m_tx_byte);
                        errors++;
                    end
                    if (m_packet_start !== want.packet_start) begin
                        $error("packet_start: expected %0d, actual %0d",
                               want.packet_start, m_packet_start);
                        errors++;
                    end
                    if (m_command_done !== want.command_done) begin
                        $error("command_done: expected %0d, actual %0d",
                               want.command_done, m_command_done);
                        errors++;
                    end
                    if (m_last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0d, actual %0d",
                               want.last_of_run, m_last_of_run);
                        errors++;
                    end
                end
            end
        end
    end

    // ---------------- receiver ----------------

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_gap = HOLD_CYCLES;
            end else if (rx_gap == 0 && idle_on && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(1, 16);
            end
            if (rx_gap > 0) begin
                m_ready <= 1'b0;
                rx_gap--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- sender side ----------------

    task automatic send_item(input logic act, input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_action          <= act;
        s_data_byte       <= b;
        s_last_of_command <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender goes quiet until every predicted byte is out
    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_tx.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_code(input logic [7:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_byte();
        return ($urandom_range(0, 3) == 0) ? spf_pkg::START_BYTE : 8'($urandom);
    endfunction

    task automatic send_command(input int n_payload);
        send_item(ACT_HEADER, rand_byte(), n_payload == 0);
        for (int i = 0; i < n_payload; i++)
            send_item(ACT_PAYLOAD, rand_byte(), i == n_payload - 1);
    endtask

    // ---------------- tests ----------------

    // payload with no open packet, first with the reset continuation code, then 0xEE
    task automatic test_orphan_payload();
        send_item(ACT_PAYLOAD, 8'h12, 1'b0);
        send_item(ACT_PAYLOAD, 8'hEE, 1'b1);
        wait_drain();
        write_code(8'hEE);
        send_item(ACT_PAYLOAD, 8'hFF, 1'b1);
        send_item(ACT_PAYLOAD, 8'h00, 1'b0);
        wait_drain();
    endtask

    task automatic test_empty_commands();
        send_item(ACT_HEADER, 8'h00, 1'b1);
        send_item(ACT_HEADER, 8'hEE, 1'b1);
        send_item(ACT_HEADER, 8'hFF, 1'b1);
        send_item(ACT_PAYLOAD, 8'h7F, 1'b1);
        wait_drain();
    endtask

    // a header arriving mid-command drops the old one
    task automatic test_abandoned_command();
        send_item(ACT_HEADER, 8'h41, 1'b0);
        send_item(ACT_PAYLOAD, 8'h00, 1'b0);
        send_item(ACT_PAYLOAD, 8'hEE, 1'b0);
        send_item(ACT_HEADER, 8'h42, 1'b0);
        send_item(ACT_PAYLOAD, 8'hFF, 1'b0);
        send_item(ACT_PAYLOAD, 8'h80, 1'b1);
        wait_drain();
    endtask

    // fill to one short of full, then a stuffed byte needs two slots;
    // later fill exactly full and overflow by one plain byte
    task automatic test_packet_boundary();
        send_item(ACT_HEADER, 8'h10, 1'b0);
        repeat (30) send_item(ACT_PAYLOAD, 8'hEE, 1'b0);
        send_item(ACT_PAYLOAD, 8'h55, 1'b0);
        send_item(ACT_PAYLOAD, 8'hEE, 1'b0);
        repeat (FRAME_BYTES - 5) send_item(ACT_PAYLOAD, 8'h00, 1'b0);
        send_item(ACT_PAYLOAD, 8'h01, 1'b1);
        wait_drain();
    endtask

    // long receiver stall while the sender keeps offering transactions
    task automatic test_backpressure();
        rx_hold_req = 1'b1;
        repeat (8) send_command($urandom_range(0, 4));
        wait_drain();
    endtask

    task automatic test_random_phase(input logic [7:0] code, input int quota);
        int sent;
        int n;
        write_code(code);
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 9) == 0) begin
                // stray transaction, any combination of fields
                send_item(1'($urandom), 8'($urandom), 1'($urandom));
                sent++;
            end else begin
                case ($urandom_range(0, 19))
                    0:       n = $urandom_range(60, 80);
                    1, 2, 3: n = $urandom_range(10, 30);
                    default: n = $urandom_range(0, 6);
                endcase
                // keep the phase within its quota
                if (sent + 1 + n > quota)
                    n = quota - sent - 1;
                if ($urandom_range(0, 7) == 0) begin
                    // broken sequence: cut short without a final byte
                    send_item(ACT_HEADER, rand_byte(), 1'b0);
                    for (int i = 0; i < n / 2; i++)
                        send_item(ACT_PAYLOAD, rand_byte(), 1'b0);
                    sent += 1 + n / 2;
                end else begin
                    send_command(n);
                    sent += 1 + n;
                end
            end
        end
        random_sent += sent;
        wait_drain();
    endtask

    initial begin
        s_valid           = 1'b0;
        s_action          = 1'b0;
        s_data_byte       = '0;
        s_last_of_command = 1'b0;
        cfg_valid         = 1'b0;
        cfg_data          = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_orphan_payload();
        test_empty_commands();
        test_abandoned_command();
        test_packet_boundary();
        test_backpressure();
        test_random_phase(8'($urandom), 12);
        test_random_phase(8'h00, 12);
        test_random_phase(8'hFF, 8);
        idle_on = 1'b0;
        test_random_phase(8'($urandom), RANDOM_ITEMS - random_sent);

        if (errors == 0 && pending_tx.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
